FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Operation and status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PORT_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 3;
  localparam int unsigned COUNT_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // capture the incoming request
    logic execute;  // apply the held request and load the result register
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } spq_stat_t;

endpackage

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: request sequencer
// Takes one request, holds off the input until the datapath has applied it
// and written its result.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.accept  = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register is free
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_exec_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> stat.out_free)
    else $error("execute issued while result register busy");
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_EXEC) && in_stall)
    else $error("accepted request not held for execution");
  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !cmd.accept)
    else $error("second request accepted before first executed");
`endif

endmodule

FILE: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath: sorted entry row, count and result register
// All entries are compared with the request value in parallel; insert and
// delete shift the row by one place around the match point.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spq_pkg::spq_cmd_t                     cmd,
  output spq_pkg::spq_stat_t                    stat,
  input  logic [spq_pkg::OP_W-1:0]              in_op,
  input  logic signed [spq_pkg::PORT_W-1:0]     in_item_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [spq_pkg::STATUS_W-1:0]          out_status,
  output logic [spq_pkg::FOUND_W-1:0]           out_found_index,
  output logic [spq_pkg::COUNT_W-1:0]           out_entry_count,
  output logic signed [spq_pkg::PORT_W-1:0]     out_top_value,
  output logic                                  out_top_valid
);
  import spq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // held request
  logic [OP_W-1:0]  op_r;
  value_t           value_r;

  value_t           entry_r   [DEPTH];
  value_t           entry_nxt [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [FOUND_W-1:0]   out_found_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic [PORT_W-1:0]    out_top_r;
  logic                 out_top_valid_r;

  logic [DEPTH-1:0] live;     // position holds a stored entry
  logic [DEPTH-1:0] ge;       // request >= entry
  logic [DEPTH-1:0] le;       // entry <= request
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] after;    // position at or past the insert point
  logic [DEPTH-1:0] last_eq;  // last of the run of equal entries
  value_t           ins_val [DEPTH];
  value_t           del_val [DEPTH];
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             full;

  status_t          status_nxt;
  logic [IDX_W-1:0] found_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign live[i]  = CNT_W'(i) < count_r;
    assign ge[i]    = value_r >= entry_r[i];
    assign le[i]    = entry_r[i] <= value_r;
    assign eq[i]    = live[i] && (entry_r[i] == value_r);
    assign after[i] = ge[i] || !live[i];
    if (i == 0) begin : g_first
      assign ins_val[i] = after[i] ? value_r : entry_r[i];
    end else begin : g_rest
      assign ins_val[i] = !after[i]    ? entry_r[i] :
                          after[i-1]   ? entry_r[i-1] : value_r;
    end
    if (i == DEPTH - 1) begin : g_tail
      assign del_val[i] = entry_r[i];
      assign last_eq[i] = eq[i];
    end else begin : g_body
      // sorted row: from the first equal entry on, every entry is <= request
      assign del_val[i] = le[i] ? entry_r[i+1] : entry_r[i];
      assign last_eq[i] = eq[i] && !eq[i+1];
    end
  end

  assign hit  = |eq;
  assign full = (count_r == CNT_W'(DEPTH));

  // equal entries are contiguous, so last_eq is one-hot or zero
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (last_eq[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    entry_nxt  = entry_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    found_nxt  = '0;
    unique case (op_t'(op_r))
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          entry_nxt = ins_val;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          entry_nxt = del_val;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          found_nxt = hit_idx;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: ;  // unused code: report state only
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      value_r <= VALUE_BITS'(in_item_value);
    end
    if (cmd.execute) begin
      entry_r         <= entry_nxt;
      out_status_r    <= status_nxt;
      out_found_r     <= FOUND_W'(found_nxt);
      out_count_r     <= COUNT_W'(count_nxt);
      out_top_r       <= (count_nxt != '0) ? PORT_W'(entry_nxt[0]) : '0;
      out_top_valid_r <= (count_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.execute) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_top_value   = out_top_r;
  assign out_top_valid   = out_top_valid_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");
  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("result not presented after execute");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> full)
    else $error("full status with free space");
  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_top_valid_r == (count_r != '0)))
    else $error("top valid disagrees with count");
`endif

endmodule

FILE: design/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted-array priority queue
// Holds up to DEPTH signed values in descending order with insert, delete by
// value and search; every request returns status, count and top value.
// ----------------------------------------------------------------------------
// A request is first captured; then the whole entry row is compared against
// the value and shifted in parallel and the result register is loaded; the
// controller takes the next request in the cycle after that. A pending result
// in the output register does not block capture, but execution waits until
// that register is free. No clearing pass is needed after reset.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spq_pkg::OP_W-1:0]          in_op,
  input  logic signed [spq_pkg::PORT_W-1:0] in_item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output logic [spq_pkg::FOUND_W-1:0]       out_found_index,
  output logic [spq_pkg::COUNT_W-1:0]       out_entry_count,
  output logic signed [spq_pkg::PORT_W-1:0] out_top_value,
  output logic                              out_top_valid
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count),
    .out_top_value   (out_top_value),
    .out_top_valid   (out_top_valid)
  );

endmodule
